### hdl/shortest_queue_dispatcher_core_assert.svh
// Assertion macros for the shortest queue dispatcher core.
// Each macro takes a label, the clock, the active-low reset and expressions.
`ifndef SHORTEST_QUEUE_DISPATCHER_CORE_ASSERT_SVH
`define SHORTEST_QUEUE_DISPATCHER_CORE_ASSERT_SVH

// Condition must hold at every edge out of reset.
`define SQD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("sqd invariant violated");

// Consequence must hold in the same cycle as the antecedent.
`define SQD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sqd implication violated");

// Consequence must hold in the cycle after the antecedent.
`define SQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sqd next-cycle check violated");

`endif

### hdl/sqd_pkg.sv
// ----------------------------------------------------------------------------
// sqd_pkg
// Sizes, codes, types and helpers shared by the shortest queue dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package sqd_pkg;

  localparam int NUM_DESKS    = 4;
  localparam int QUEUE_DEPTH  = 8;
  localparam int CLIENT_WIDTH = 16;

  localparam int DESK_W    = $clog2(NUM_DESKS);
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = NUM_DESKS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Field widths fixed by the ports
  localparam int KIND_W     = 1;
  localparam int STATUS_W   = 2;
  localparam int DESK_FLD_W = 2;
  localparam int CLIENT_FLD_W = 16;
  localparam int LEN_FLD_W  = 4;

  localparam logic [KIND_W-1:0] KIND_ARRIVE = 1'b0;
  localparam logic [KIND_W-1:0] KIND_SERVE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  typedef logic [DESK_W-1:0]       desk_t;
  typedef logic [PTR_W-1:0]        ptr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CLIENT_WIDTH-1:0] client_t;
  typedef logic [ADDR_W-1:0]       addr_t;

  typedef struct packed {
    desk_t desk;
    cnt_t  count;
  } pick_t;

  function automatic ptr_t next_slot(ptr_t p);
    ptr_t r;
    if (int'(p) == QUEUE_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic addr_t slot_addr(desk_t d, ptr_t p);
    int a;
    a = int'(d) * QUEUE_DEPTH + int'(p);
    return addr_t'(a);
  endfunction

endpackage

`default_nettype wire

### hdl/sqd_ram.sv
// ----------------------------------------------------------------------------
// sqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/sqd_pick.sv
// ----------------------------------------------------------------------------
// sqd_pick
// Finds the desk with the fewest waiting words; ties go to the lowest index.
// ----------------------------------------------------------------------------
`default_nettype none

module sqd_pick
  import sqd_pkg::*;
(
  input  wire cnt_t  count_i [NUM_DESKS],
  output      pick_t pick_o
);

  always_comb begin
    pick_o.desk  = '0;
    pick_o.count = count_i[0];
    // strict less-than keeps the earlier desk on a tie
    for (int d = 1; d < NUM_DESKS; d++) begin
      if (count_i[d] < pick_o.count) begin
        pick_o.desk  = desk_t'(d);
        pick_o.count = count_i[d];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/shortest_queue_dispatcher_core.sv
// ----------------------------------------------------------------------------
// shortest_queue_dispatcher_core
// Join-shortest-queue dispatcher: one ring FIFO of client ids per desk.
// ----------------------------------------------------------------------------
//   channel | valid       | stall       | words
//   --------+-------------+-------------+----------------------------------------
//   in      | in_valid_i  | in_stall_o  | kind, client_id, serve_desk
//   out     | out_valid_o | out_stall_i | status, chosen_desk, served_client,
//           |             |             | queue_length
//
// One word per cycle sustained while out_stall_i is low; a word passes the input
// register, then the result register, with the client RAM read alongside it.
// Reset clears counts, pointers and valids at once; the client store is not
// cleared. A stalled output holds its word and stops the input register,
// which then raises in_stall_o in the same cycle.
`default_nettype none

`include "shortest_queue_dispatcher_core_assert.svh"

module shortest_queue_dispatcher_core
  import sqd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_stall_o,
  input  wire logic [KIND_W-1:0]       kind_i,
  input  wire logic [CLIENT_FLD_W-1:0] client_id_i,
  input  wire logic [DESK_FLD_W-1:0]   serve_desk_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_stall_i,
  output      logic [STATUS_W-1:0]     status_o,
  output      logic [DESK_FLD_W-1:0]   chosen_desk_o,
  output      logic [CLIENT_FLD_W-1:0] served_client_o,
  output      logic [LEN_FLD_W-1:0]    queue_length_o
);

  // Input register
  logic                  in_vld_q, in_vld_d;
  logic [KIND_W-1:0]     in_kind_q;
  client_t               in_client_q, in_client_d;
  logic [DESK_FLD_W-1:0] in_desk_q;

  // Queue state
  cnt_t count_q [NUM_DESKS];
  ptr_t head_q  [NUM_DESKS];
  ptr_t tail_q  [NUM_DESKS];

  // Result register
  logic                  out_vld_q, out_vld_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [DESK_FLD_W-1:0] out_desk_q, out_desk_d;
  client_t               out_client_q, out_client_d;
  cnt_t                  out_len_q, out_len_d;
  logic                  out_from_ram_q, out_from_ram_d;

  logic    in_acc, advance;
  pick_t   pick;
  logic    arrive_ok, serve_ok;
  desk_t   serve_idx;
  logic    ram_we, ram_re;
  addr_t   ram_waddr, ram_raddr;
  client_t ram_rdata;

  logic [31:0] cid_ext, pick_desk_ext, serve_ext, sc_ext, len_ext;

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_acc || (in_vld_q && !advance);

  assign cid_ext     = 32'(client_id_i);
  assign in_client_d = cid_ext[CLIENT_WIDTH-1:0];

  sqd_pick u_pick (
    .count_i (count_q),
    .pick_o  (pick)
  );

  assign serve_ext     = 32'(in_desk_q);
  assign serve_idx     = serve_ext[DESK_W-1:0];
  assign pick_desk_ext = 32'(pick.desk);

  assign arrive_ok = (in_kind_q == KIND_ARRIVE) && (int'(pick.count) < QUEUE_DEPTH);
  assign serve_ok  = (in_kind_q == KIND_SERVE) && (int'(in_desk_q) < NUM_DESKS)
                     && (count_q[serve_idx] != '0);

  assign ram_we    = advance && arrive_ok;
  assign ram_re    = advance && serve_ok;
  assign ram_waddr = slot_addr(pick.desk, tail_q[pick.desk]);
  assign ram_raddr = slot_addr(serve_idx, head_q[serve_idx]);

  sqd_ram #(
    .Width (CLIENT_WIDTH),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_client_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_status_d   = STATUS_OK;
    out_desk_d     = in_desk_q;
    out_client_d   = '0;
    out_len_d      = '0;
    out_from_ram_d = 1'b0;
    if (in_kind_q == KIND_ARRIVE) begin
      if (arrive_ok) begin
        out_desk_d   = pick_desk_ext[DESK_FLD_W-1:0];
        out_client_d = in_client_q;
        out_len_d    = pick.count + cnt_t'(1);
      end else begin
        out_status_d = STATUS_FULL;
        out_desk_d   = '0;
        out_len_d    = cnt_t'(QUEUE_DEPTH);
      end
    end else begin
      if (serve_ok) begin
        out_from_ram_d = 1'b1;
        out_len_d      = count_q[serve_idx] - cnt_t'(1);
      end else begin
        out_status_d = STATUS_EMPTY;
      end
    end
  end

  assign out_vld_d = advance || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int d = 0; d < NUM_DESKS; d++) begin
        count_q[d] <= '0;
        head_q[d]  <= '0;
        tail_q[d]  <= '0;
      end
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (ram_we) begin
        count_q[pick.desk] <= pick.count + cnt_t'(1);
        tail_q[pick.desk]  <= next_slot(tail_q[pick.desk]);
      end
      if (ram_re) begin
        count_q[serve_idx] <= count_q[serve_idx] - cnt_t'(1);
        head_q[serve_idx]  <= next_slot(head_q[serve_idx]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_kind_q   <= kind_i;
      in_client_q <= in_client_d;
      in_desk_q   <= serve_desk_i;
    end
    if (advance) begin
      out_status_q   <= out_status_d;
      out_desk_q     <= out_desk_d;
      out_client_q   <= out_client_d;
      out_len_q      <= out_len_d;
      out_from_ram_q <= out_from_ram_d;
    end
  end

  // popped word arrives from the registered RAM read, in the cycle after the read
  assign sc_ext  = 32'(out_from_ram_q ? ram_rdata : out_client_q);
  assign len_ext = 32'(out_len_q);

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign chosen_desk_o   = out_desk_q;
  assign served_client_o = sc_ext[CLIENT_FLD_W-1:0];
  assign queue_length_o  = len_ext[LEN_FLD_W-1:0];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < NUM_DESKS; g++) begin : g_chk
    logic [CNT_W:0] wrap_sum;
    logic [CNT_W:0] wrap_pos;
    logic           ring_ok;
    assign wrap_sum = (CNT_W+1)'(head_q[g]) + (CNT_W+1)'(count_q[g]);
    assign wrap_pos = (int'(wrap_sum) >= QUEUE_DEPTH) ?
                      wrap_sum - (CNT_W+1)'(QUEUE_DEPTH) : wrap_sum;
    assign ring_ok  = (int'(count_q[g]) <= QUEUE_DEPTH) &&
                      (wrap_pos == (CNT_W+1)'(tail_q[g]));
    `SQD_ASSERT_ALWAYS(a_ring_consistent, clk_i, rst_ni, ring_ok)
  end

  `SQD_ASSERT_NEXT(a_read_lands, clk_i, rst_ni, ram_re, out_vld_q && out_from_ram_q)
  `SQD_ASSERT_IMPLY(a_ram_only_ok, clk_i, rst_ni, out_vld_q && out_from_ram_q, out_status_q == STATUS_OK)

endmodule

`default_nettype wire
